// File: rtl/core/stun_binding_response_parser_core_macros.svh
// ----------------------------------------------------------------------------
// STUN binding response parser: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH
`define STUN_BINDING_RESPONSE_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define SBRP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// STUN binding response parser package
// Payload types, status codes and protocol constants.
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam int MAX_MESSAGE_BYTES_DEF = 2048;

  localparam logic [31:0] XOR_KEY      = 32'h2112_A442;
  localparam logic [15:0] ATTR_XMA     = 16'h0020;
  localparam logic [15:0] ATTR_XMA_OLD = 16'h8020;
  localparam logic [7:0]  HEADER_BYTE  = 8'h01;
  localparam int          HEADER_LEN   = 20;
  localparam logic [7:0]  FAMILY_IPV4  = 8'h01;
  localparam int          MIN_XMA_LEN  = 8;

  // wide enough for attribute start + 4 + padded 16-bit length
  localparam int SUM_W = 18;

  typedef enum logic [1:0] {
    MS_SEARCH,
    MS_FOUND,
    MS_STOP
  } match_state_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_NOT_SUCCESS,
    ST_NO_ADDR,
    ST_NON_IPV4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
  } out_item_t;

endpackage

// File: rtl/core/sbrp_walker.sv
// ----------------------------------------------------------------------------
// STUN binding response parser: attribute walker
// Per-datagram parse state, updated once per byte, and the end-of-datagram
// verdict.
// ----------------------------------------------------------------------------
module sbrp_walker
  import sbrp_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_MESSAGE_BYTES);
  localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_MESSAGE_BYTES);
  localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_LEN);

  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic             header_bad, header_bad_next;
  logic [OFF_W-1:0] attr_start, attr_start_next;
  logic [31:0]      attr_header_word, attr_header_word_next;
  match_state_t     match_state, match_state_next;
  logic [OFF_W-1:0] match_end, match_end_next;
  logic [7:0]       addr_family, addr_family_next;
  logic [15:0]      masked_port, masked_port_next;
  logic [31:0]      masked_ip, masked_ip_next;

  logic             in_range;
  logic [OFF_W-1:0] rel;
  logic [OFF_W-1:0] n;
  logic [31:0]      hw_shift;
  logic [15:0]      a_type, a_len;
  logic [SUM_W-1:0] end_sum, pad_len, next_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      header_bad       <= 1'b0;
      attr_start       <= HDR_OFF;
      attr_header_word <= '0;
      match_state      <= MS_SEARCH;
      match_end        <= '0;
      addr_family      <= '0;
      masked_port      <= '0;
      masked_ip        <= '0;
    end else begin
      byte_offset      <= byte_offset_next;
      header_bad       <= header_bad_next;
      attr_start       <= attr_start_next;
      attr_header_word <= attr_header_word_next;
      match_state      <= match_state_next;
      match_end        <= match_end_next;
      addr_family      <= addr_family_next;
      masked_port      <= masked_port_next;
      masked_ip        <= masked_ip_next;
    end
  end

  always_comb begin
    byte_offset_next      = byte_offset;
    header_bad_next       = header_bad;
    attr_start_next       = attr_start;
    attr_header_word_next = attr_header_word;
    match_state_next      = match_state;
    match_end_next        = match_end;
    addr_family_next      = addr_family;
    masked_port_next      = masked_port;
    masked_ip_next        = masked_ip;

    in_range = (byte_offset < MAX_OFF);
    rel      = byte_offset - attr_start;
    hw_shift = {attr_header_word[23:0], item.rx_byte};
    a_type   = hw_shift[31:16];
    a_len    = hw_shift[15:0];
    end_sum  = SUM_W'(attr_start) + SUM_W'(4) + SUM_W'(a_len);
    pad_len  = (SUM_W'(a_len) + SUM_W'(3)) & ~SUM_W'(3);
    next_sum = SUM_W'(attr_start) + SUM_W'(4) + pad_len;
    n        = in_range ? byte_offset + OFF_W'(1) : byte_offset;

    if (step && in_range) begin
      byte_offset_next = byte_offset + OFF_W'(1);
      if ((byte_offset == OFF_W'(0) || byte_offset == OFF_W'(1)) &&
          item.rx_byte != HEADER_BYTE) begin
        header_bad_next = 1'b1;
      end
      if (match_state == MS_SEARCH && byte_offset >= HDR_OFF &&
          byte_offset >= attr_start) begin
        if (rel < OFF_W'(4)) begin
          attr_header_word_next = hw_shift;
        end
        if (rel == OFF_W'(3)) begin
          if ((a_type == ATTR_XMA || a_type == ATTR_XMA_OLD) &&
              a_len >= 16'(MIN_XMA_LEN)) begin
            if (end_sum > MAX_SUM) begin
              match_state_next = MS_STOP;
            end else begin
              match_state_next = MS_FOUND;
              match_end_next   = end_sum[OFF_W-1:0];
            end
          end else if (next_sum >= MAX_SUM) begin
            match_state_next = MS_STOP;
          end else begin
            attr_start_next       = next_sum[OFF_W-1:0];
            attr_header_word_next = '0;
          end
        end
      end else if (match_state == MS_FOUND && byte_offset >= attr_start) begin
        if (rel == OFF_W'(5)) begin
          addr_family_next = item.rx_byte;
        end else if (rel == OFF_W'(6) || rel == OFF_W'(7)) begin
          masked_port_next = {masked_port[7:0], item.rx_byte};
        end else if (rel inside {[8:11]}) begin
          masked_ip_next = {masked_ip[23:0], item.rx_byte};
        end
      end
    end

    // An attribute found on this very byte always ends past n, and a family
    // byte taken now lies in such an attribute, so the stored values suffice.
    res = '0;
    if (n < HDR_OFF) begin
      res.status = ST_SHORT;
    end else if (header_bad_next) begin
      res.status = ST_NOT_SUCCESS;
    end else if (match_state == MS_FOUND && match_end <= n) begin
      if (addr_family == FAMILY_IPV4) begin
        res.status      = ST_OK;
        res.mapped_ip   = masked_ip_next ^ XOR_KEY;
        res.mapped_port = masked_port_next ^ XOR_KEY[31:16];
      end else begin
        res.status = ST_NON_IPV4;
      end
    end else begin
      res.status = ST_NO_ADDR;
    end

    if (step && item.last_byte) begin
      byte_offset_next      = '0;
      header_bad_next       = 1'b0;
      attr_start_next       = HDR_OFF;
      attr_header_word_next = '0;
      match_state_next      = MS_SEARCH;
      match_end_next        = '0;
      addr_family_next      = '0;
      masked_port_next      = '0;
      masked_ip_next        = '0;
    end
  end

endmodule

// File: rtl/core/sbrp_out_reg.sv
// ----------------------------------------------------------------------------
// STUN binding response parser: result register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module sbrp_out_reg
  import sbrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t d,
  input  logic      stall,
  output logic      valid,
  output out_item_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// File: rtl/core/stun_binding_response_parser_core.sv
// ----------------------------------------------------------------------------
// STUN binding response parser core
// Byte-wide parser that pulls the XOR-mapped IPv4 address and port out of a
// binding success response.
// ----------------------------------------------------------------------------
// One datagram byte is taken per clock with no gaps; a byte request is held
// only while a verdict sits unread in the result register and the byte in
// the input register is the datagram's last. Each byte passes the input
// register and the parse-state update, and for the last byte the result
// register, which loads the verdict worked out combinationally from the input
// register and parse state when that byte advances. Bytes beyond
// MAX_MESSAGE_BYTES are counted out but not parsed. Parse state returns to
// its reset values after each verdict.
module stun_binding_response_parser_core
  import sbrp_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  in_item_t  byte_data,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_data
);

  logic      in_full;
  in_item_t  in_item;
  logic      advance;
  logic      accept;
  out_item_t verdict;

  // the only blocker is a last byte facing a full, stalled result register
  assign advance    = in_full && !(in_item.last_byte && result_valid && result_stall);
  assign byte_stall = in_full && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= byte_data;
    end
  end

  sbrp_walker #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_walker (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (verdict)
  );

  sbrp_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance && in_item.last_byte),
    .d     (verdict),
    .stall (result_stall),
    .valid (result_valid),
    .q     (result_data)
  );

endmodule

// File: rtl/core/sbrp_checker.sv
// ----------------------------------------------------------------------------
// STUN binding response parser: port checker
// Watches the top-level ports; bound onto the core.
// ----------------------------------------------------------------------------
`include "stun_binding_response_parser_core_macros.svh"

module sbrp_checker
  import sbrp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input in_item_t  byte_data,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result_data
);

  logic res_wait;
  logic res_fail;
  logic addr_zero;
  logic last_taken;

  assign res_wait   = result_valid && result_stall;
  assign res_fail   = result_valid && result_data.status != ST_OK;
  assign addr_zero  = result_data.mapped_ip == '0 && result_data.mapped_port == '0;
  assign last_taken = byte_valid && !byte_stall && byte_data.last_byte;

  `SBRP_ASSERT_NEXT(a_res_valid_hold, clk, rst, res_wait, result_valid, "result request dropped")
  `SBRP_ASSERT_NEXT(a_res_data_hold, clk, rst, res_wait, $stable(result_data), "result changed")
  `SBRP_ASSERT_IMPL(a_zero_on_fail, clk, rst, res_fail, addr_zero, "address on failed verdict")
  `SBRP_ASSERT_IMPL(a_res_after_last, clk, rst, $rose(result_valid), $past(last_taken, 2), "stray verdict")

endmodule

bind stun_binding_response_parser_core sbrp_checker u_sbrp_checker (.*);

// File: tb/sv/tb_stun_binding_response_parser_core.sv
// ----------------------------------------------------------------------------
// STUN binding response parser core testbench
// Sends whole datagrams a byte at a time: a table of hand-built cases, a
// back-pressure phase and random datagrams. A byte-level parser model works
// out each verdict on the marked last byte unless the table types it in; verdicts are
// checked in order, field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_stun_binding_response_parser_core;
  import sbrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MSG_MAX = MAX_MESSAGE_BYTES_DEF;

  logic      clk = 1'b0;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  byte_data;
  logic      result_valid;
  logic      result_stall;
  out_item_t result_data;

  stun_binding_response_parser_core #(
    .MAX_MESSAGE_BYTES(MSG_MAX)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hand-built datagram: optional leading attribute, optional address attribute
  typedef struct {
    logic [7:0]  b0;
    logic [7:0]  b1;
    int          fill_len;   // -1: no leading attribute
    logic [15:0] fill_type;
    int          xma_len;    // -1: no address attribute
    logic [15:0] xma_type;
    logic [7:0]  family;
    logic [15:0] xport;
    logic [31:0] xip;
    int          size;       // 0: as built, else cut or padded to this
    bit          fixed;      // verdict typed in below rather than predicted
    status_t     st;
    logic [31:0] ip;
    logic [15:0] port;
  } dgram_case_t;

  typedef struct {
    bit        fixed;
    out_item_t v;
  } typed_verdict_t;

  dgram_case_t dir_cases [24] = '{
    // one byte, then 19 bytes: too short
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h2112, 32'h2112_A442, 1,
      1'b1, ST_SHORT, 32'h0, 16'h0},
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h2112, 32'h2112_A442, 19,
      1'b1, ST_SHORT, 32'h0, 16'h0},
    // header only
    '{8'h01, 8'h01, -1, 16'h0000, -1, ATTR_XMA, 8'h01, 16'h0, 32'h0, 0,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    // bad message type bytes
    '{8'h00, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h1234, 32'hC0A8_0001, 0,
      1'b1, ST_NOT_SUCCESS, 32'h0, 16'h0},
    '{8'h01, 8'hFF, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h1234, 32'hC0A8_0001, 0,
      1'b1, ST_NOT_SUCCESS, 32'h0, 16'h0},
    // mask equal to the cookie decodes to zero, then all-ones and all-zero masks
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h2112, 32'h2112_A442, 0,
      1'b1, ST_OK, 32'h0, 16'h0},
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'hFFFF, 32'hFFFF_FFFF, 0,
      1'b0, ST_OK, 32'h0, 16'h0},
    '{8'h01, 8'h01, -1, 16'h0000, 12, ATTR_XMA_OLD, 8'h01, 16'h0000, 32'h0, 0,
      1'b0, ST_OK, 32'h0, 16'h0},
    // IPv6 and junk family
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h02, 16'h5555, 32'hAAAA_5555, 0,
      1'b1, ST_NON_IPV4, 32'h0, 16'h0},
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA_OLD, 8'hFF, 16'h5555, 32'hAAAA_5555, 0,
      1'b1, ST_NON_IPV4, 32'h0, 16'h0},
    // address attribute one byte too short is skipped
    '{8'h01, 8'h01, -1, 16'h0000, 7, ATTR_XMA, 8'h01, 16'h1111, 32'h2222_3333, 0,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    // odd-length attribute ahead, padding to 4
    '{8'h01, 8'h01, 5, 16'h0001, 8, ATTR_XMA, 8'h01, 16'hBEEF, 32'h0102_0304, 0,
      1'b0, ST_OK, 32'h0, 16'h0},
    '{8'h01, 8'h01, 4, ATTR_XMA, 8, ATTR_XMA_OLD, 8'h01, 16'h8001, 32'h7F00_0001, 0,
      1'b0, ST_OK, 32'h0, 16'h0},
    // attribute runs past the end of the datagram
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h1234, 32'h0A00_0001, 31,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    // attribute header cut short
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'h1234, 32'h0A00_0001, 22,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    // next header far beyond the buffer, address attribute beyond the buffer
    '{8'h01, 8'h01, 65535, 16'h8022, -1, ATTR_XMA, 8'h01, 16'h0, 32'h0, 40,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    '{8'h01, 8'h01, -1, 16'h0000, 65520, ATTR_XMA, 8'h01, 16'h1, 32'h1, 64,
      1'b1, ST_NO_ADDR, 32'h0, 16'h0},
    // overlong datagrams: last mark on a dropped byte
    '{8'h01, 8'h01, -1, 16'h0000, 8, ATTR_XMA, 8'h01, 16'hC350, 32'h5DB8_D822, 2100,
      1'b0, ST_OK, 32'h0, 16'h0},
    '{8'h01, 8'h01, 2016, 16'h0006, 8, ATTR_XMA, 8'h01, 16'h1, 32'h1, 2100,
      1'b0, ST_OK, 32'h0, 16'h0},
    '{8'h01, 8'h01, 2024, 16'h0006, -1, ATTR_XMA, 8'h01, 16'h0, 32'h0, 2060,
      1'b0, ST_OK, 32'h0, 16'h0},
    // address attribute ending exactly at the buffer limit
    '{8'h01, 8'h01, 2008, 16'h0006, 12, ATTR_XMA, 8'h01, 16'h4E20, 32'hC633_6407, 0,
      1'b0, ST_OK, 32'h0, 16'h0},
    // length check ahead of header check, header check ahead of search
    '{8'hFF, 8'h00, -1, 16'h0000, -1, ATTR_XMA, 8'h01, 16'h0, 32'h0, 5,
      1'b1, ST_SHORT, 32'h0, 16'h0},
    '{8'h01, 8'h02, -1, 16'h0000, -1, ATTR_XMA, 8'h01, 16'h0, 32'h0, 0,
      1'b1, ST_NOT_SUCCESS, 32'h0, 16'h0},
    // zero-length attribute of the address type ahead
    '{8'h01, 8'h01, 0, ATTR_XMA, 8, ATTR_XMA, 8'h01, 16'h0000, 32'h0000_0000, 0,
      1'b0, ST_OK, 32'h0, 16'h0}
  };

  logic [7:0]     msg_bytes [$];
  typed_verdict_t typed_q [$];
  out_item_t      verdict_q [$];

  int errors;
  int verdicts_checked;
  int msgs_sent;
  int bytes_sent;
  int status_seen [5];
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  // parser model state
  int           p_off;
  bit           p_hdr_bad;
  int           p_attr_start;
  logic [31:0]  p_word;
  match_state_t p_ms;
  int           p_match_end;
  logic [7:0]   p_family;
  logic [15:0]  p_port;
  logic [31:0]  p_ip;

  function automatic void parse_reset();
    p_off        = 0;
    p_hdr_bad    = 1'b0;
    p_attr_start = HEADER_LEN;
    p_word       = '0;
    p_ms         = MS_SEARCH;
    p_match_end  = 0;
    p_family     = '0;
    p_port       = '0;
    p_ip         = '0;
  endfunction

  // one byte through the parser; returns 1 with the verdict on a last byte
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output out_item_t res);
    int rel;
    int next_start;
    int end_off;
    logic [15:0] atype;
    logic [15:0] alen;
    res = '0;
    if (p_off < MSG_MAX) begin
      if (p_off < 2 && b != HEADER_BYTE) p_hdr_bad = 1'b1;
      if (p_ms == MS_SEARCH && p_off >= HEADER_LEN && p_off >= p_attr_start) begin
        rel = p_off - p_attr_start;
        if (rel < 4) p_word = {p_word[23:0], b};
        if (rel == 3) begin
          atype = p_word[31:16];
          alen  = p_word[15:0];
          if ((atype == ATTR_XMA || atype == ATTR_XMA_OLD) && alen >= MIN_XMA_LEN) begin
            end_off = p_attr_start + 4 + int'(alen);
            if (end_off > MSG_MAX) begin
              p_ms = MS_STOP;
            end else begin
              p_ms        = MS_FOUND;
              p_match_end = end_off;
            end
          end else begin
            next_start = p_attr_start + 4 + ((int'(alen) + 3) & ~3);
            if (next_start >= MSG_MAX) begin
              p_ms = MS_STOP;
            end else begin
              p_attr_start = next_start;
              p_word       = '0;
            end
          end
        end
      end else if (p_ms == MS_FOUND && p_off >= p_attr_start) begin
        rel = p_off - p_attr_start;
        if (rel == 5) p_family = b;
        else if (rel == 6 || rel == 7) p_port = {p_port[7:0], b};
        else if (rel >= 8 && rel <= 11) p_ip = {p_ip[23:0], b};
      end
      p_off++;
    end
    if (!last) return 1'b0;
    if (p_off < HEADER_LEN) begin
      res.status = ST_SHORT;
    end else if (p_hdr_bad) begin
      res.status = ST_NOT_SUCCESS;
    end else if (p_ms == MS_FOUND && p_match_end <= p_off) begin
      if (p_family == FAMILY_IPV4) begin
        res.status      = ST_OK;
        res.mapped_ip   = p_ip ^ XOR_KEY;
        res.mapped_port = p_port ^ XOR_KEY[31:16];
      end else begin
        res.status = ST_NON_IPV4;
      end
    end else begin
      res.status = ST_NO_ADDR;
    end
    parse_reset();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // accepted bytes feed the model
  always @(posedge clk) begin
    out_item_t      pred;
    typed_verdict_t tv;
    if (!rst && byte_valid && !byte_stall) begin
      if (parse_byte(byte_data.rx_byte, byte_data.last_byte, pred)) begin
        if (typed_q.size() != 0) begin
          tv = typed_q.pop_front();
          if (tv.fixed) pred = tv.v;
        end
        verdict_q.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      verdicts_checked++;
      if (result_data.status < 5) status_seen[result_data.status]++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected verdict status", result_data.status, 0);
      end else begin
        want = verdict_q.pop_front();
        if (result_data.status !== want.status)
          report_mismatch("status", result_data.status, want.status);
        if (result_data.mapped_ip !== want.mapped_ip)
          report_mismatch("mapped_ip", result_data.mapped_ip, want.mapped_ip);
        if (result_data.mapped_port !== want.mapped_port)
          report_mismatch("mapped_port", result_data.mapped_port, want.mapped_port);
      end
    end
  end

  // result side: random stalls, or a long hold when asked for
  initial begin
    int hold_left;
    hold_left    = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= rx_idle_on && ($urandom_range(0, 99) < 15);
      end
    end
  end

  function automatic void put_rand(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_header(input logic [7:0] b0, input logic [7:0] b1);
    msg_bytes.push_back(b0);
    msg_bytes.push_back(b1);
    put_rand(2);
    for (int i = 3; i >= 0; i--) msg_bytes.push_back(XOR_KEY[i*8 +: 8]);
    put_rand(12);
  endfunction

  function automatic void put_attr_hdr(input logic [15:0] atype, input int len);
    logic [15:0] l16;
    l16 = 16'(len);
    msg_bytes.push_back(atype[15:8]);
    msg_bytes.push_back(atype[7:0]);
    msg_bytes.push_back(l16[15:8]);
    msg_bytes.push_back(l16[7:0]);
  endfunction

  // huge lengths get their header only; the datagram is sized afterwards
  function automatic void put_attr(input logic [15:0] atype, input int len);
    put_attr_hdr(atype, len);
    if (len <= 4096) put_rand((len + 3) & ~3);
  endfunction

  function automatic void put_xma(input logic [15:0] atype, input int len,
                                  input logic [7:0] fam, input logic [15:0] xport,
                                  input logic [31:0] xip);
    put_attr_hdr(atype, len);
    put_rand(1);
    msg_bytes.push_back(fam);
    msg_bytes.push_back(xport[15:8]);
    msg_bytes.push_back(xport[7:0]);
    for (int i = 3; i >= 0; i--) msg_bytes.push_back(xip[i*8 +: 8]);
    if (len > 8 && len <= 4096) put_rand(((len + 3) & ~3) - 8);
  endfunction

  function automatic void fit_size(input int n);
    while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    if (msg_bytes.size() < n) put_rand(n - msg_bytes.size());
  endfunction

  function automatic void make_random_msg();
    int kind;
    int n;
    int r;
    int xlen;
    logic [7:0] fam;
    kind = $urandom_range(0, 99);
    msg_bytes.delete();
    if (kind < 80 || kind >= 97) begin
      if (kind >= 70 && kind < 80)
        put_header($urandom_range(0, 1) ? 8'($urandom) : HEADER_BYTE,
                   $urandom_range(0, 1) ? 8'($urandom) : HEADER_BYTE);
      else
        put_header(HEADER_BYTE, HEADER_BYTE);
      repeat ($urandom_range(0, 3))
        put_attr(($urandom_range(0, 7) == 0) ? ATTR_XMA : 16'($urandom),
                 $urandom_range(0, 12));
      r = $urandom_range(0, 9);
      if (r <= 5) xlen = 8;
      else if (r <= 7) xlen = 12;
      else if (r == 8) xlen = $urandom_range(4, 7);
      else xlen = $urandom_range(9, 20);
      fam = ($urandom_range(0, 99) < 85) ? FAMILY_IPV4 : 8'($urandom);
      put_xma($urandom_range(0, 1) ? ATTR_XMA : ATTR_XMA_OLD, xlen, fam,
              16'($urandom), $urandom);
      if ($urandom_range(0, 9) < 3) put_attr(16'($urandom), $urandom_range(0, 8));
      if (kind >= 97) fit_size($urandom_range(MSG_MAX - 8, MSG_MAX + 52));
      else if ($urandom_range(0, 99) < 15) fit_size(msg_bytes.size() - $urandom_range(1, 6));
    end else begin
      n = $urandom_range(1, 40);
      if (n >= 2 && $urandom_range(0, 1)) begin
        msg_bytes.push_back(HEADER_BYTE);
        msg_bytes.push_back(HEADER_BYTE);
        put_rand(n - 2);
      end else begin
        put_rand(n);
      end
    end
  endfunction

  // entered and left at a falling edge; valid is written once per edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (tx_idle_on && $urandom_range(0, 99) < 15) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{rx_byte: b, last_byte: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_msg(input bit fixed, input out_item_t v);
    typed_q.push_back('{fixed: fixed, v: v});
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msgs_sent++;
    bytes_sent += msg_bytes.size();
  endtask

  task automatic drain_wait();
    byte_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    out_item_t want;
    int rnd_msgs;
    int rnd_bytes;
    errors = 0;
    verdicts_checked = 0;
    msgs_sent = 0;
    bytes_sent = 0;
    hold_req = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    parse_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_cases[i]) begin
      msg_bytes.delete();
      put_header(dir_cases[i].b0, dir_cases[i].b1);
      if (dir_cases[i].fill_len >= 0) put_attr(dir_cases[i].fill_type, dir_cases[i].fill_len);
      if (dir_cases[i].xma_len >= 0)
        put_xma(dir_cases[i].xma_type, dir_cases[i].xma_len, dir_cases[i].family,
                dir_cases[i].xport, dir_cases[i].xip);
      if (dir_cases[i].size > 0) fit_size(dir_cases[i].size);
      want = '{status: dir_cases[i].st, mapped_ip: dir_cases[i].ip,
               mapped_port: dir_cases[i].port};
      send_msg(dir_cases[i].fixed, want);
    end
    drain_wait();

    // verdicts pile up behind a long hold until byte requests stall
    hold_req = 1'b1;
    repeat (6) begin
      msg_bytes.delete();
      put_rand($urandom_range(1, 24));
      send_msg(1'b0, '0);
    end
    drain_wait();

    rnd_msgs = 0;
    rnd_bytes = 0;
    while (rnd_bytes < 850 || rnd_msgs < 48) begin
      tx_idle_on = !(rnd_msgs >= 15 && rnd_msgs < 27);
      rx_idle_on = tx_idle_on;
      make_random_msg();
      rnd_bytes += (msg_bytes.size() < MSG_MAX) ? msg_bytes.size() : MSG_MAX;
      send_msg(1'b0, '0);
      rnd_msgs++;
      if (rnd_msgs % 13 == 0) drain_wait();
    end
    drain_wait();
    repeat (10) @(posedge clk);

    $display("Ran %0d datagrams (%0d bytes), %0d verdicts checked", msgs_sent, bytes_sent,
             verdicts_checked);
    $display("Verdicts ok/short/bad type/no address/non-IPv4: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d verdicts outstanding", verdict_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
